FILE: rtl/lnpw_pkg.sv
// shared constants for the longest near-palindrome window block
// no dependencies
package lnpw_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int CHAR_W      = 8;
  localparam int K_W         = 7;
  localparam int OUT_W       = 7;

endpackage

FILE: rtl/lnpw_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module lnpw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/longest_near_palindrome_window.sv
// longest near-palindrome window: top level with text and cost memories
// depends on lnpw_pkg and lnpw_ram
//
// Characters load one per cycle, while char_stall is low, into the text
// memory. The item that carries is_last starts the cost fill: every
// substring of length two or more is visited in turn, with three reads on
// the single read port of the cost memory and then a write of its cost.
// result_valid rises once the fill is done and the output is free. No new
// character is taken during the fill; loading of the next string may run
// while the result waits to be taken. Characters beyond MAX_LEN are
// dropped. A single character always qualifies, so each string yields
// exactly one result.
module longest_near_palindrome_window #(
  parameter int MAX_LEN = lnpw_pkg::MAX_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [lnpw_pkg::K_W-1:0]   wr_data,
  input  logic                       char_valid,
  output logic                       char_stall,
  input  logic [lnpw_pkg::CHAR_W-1:0] char_byte,
  input  logic                       is_last,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [lnpw_pkg::OUT_W-1:0] best_start,
  output logic [lnpw_pkg::OUT_W-1:0] best_end
);

  import lnpw_pkg::*;

  localparam int IW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int NW     = IW + 1;
  localparam int CW     = IW;
  localparam int KCW    = (CW > K_W) ? CW : K_W;
  localparam int CDEPTH = 1 << (2 * IW);

  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_FILL = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]        state;
  logic [1:0]        ph;
  logic [NW-1:0]     text_length;
  logic [NW-1:0]     n;
  logic [NW-1:0]     len;
  logic [IW-1:0]     l;
  logic [IW-1:0]     bs;
  logic [NW-1:0]     bl;
  logic [K_W-1:0]    max_deletions;
  logic [CW-1:0]     a;
  logic [CW-1:0]     b;
  logic [CHAR_W-1:0] tl;
  logic [CHAR_W-1:0] tr;

  logic              char_acc;
  logic              text_we;
  logic [IW-1:0]     text_raddr;
  logic [CHAR_W-1:0] text_rd;
  logic [IW-1:0]     r;
  logic [IW-1:0]     lp1;
  logic [IW-1:0]     rm1;
  logic [2*IW-1:0]   cost_raddr;
  logic [CW-1:0]     cost_rd;
  logic              cost_we;
  logic [CW-1:0]     a_eff;
  logic [CW-1:0]     b_eff;
  logic [CW-1:0]     inner;
  logic [CW-1:0]     skip_cost;
  logic [CW-1:0]     cell_cost;
  logic              qualifies;
  logic              row_end;
  logic              slot_free;
  logic [NW-1:0]     count_next;

  assign char_stall = (state != S_LOAD);
  assign char_acc   = char_valid && !char_stall;
  assign text_we    = char_acc && (text_length < NW'(MAX_LEN));
  assign count_next = text_we ? text_length + NW'(1) : text_length;
  assign slot_free  = !result_valid || !result_stall;

  assign r   = IW'(NW'(l) + len - NW'(1));
  assign lp1 = l + IW'(1);
  assign rm1 = r - IW'(1);

  always_comb begin
    case (ph)
      2'd0:    cost_raddr = {lp1, r};
      2'd1:    cost_raddr = {l, rm1};
      default: cost_raddr = {lp1, rm1};
    endcase
    text_raddr = (ph == 2'd0) ? l : r;
  end

  always_comb begin
    a_eff     = (len == NW'(2)) ? '0 : a;
    b_eff     = (len == NW'(2)) ? '0 : b;
    inner     = (len <= NW'(3)) ? '0 : cost_rd;
    skip_cost = ((a_eff < b_eff) ? a_eff : b_eff) + CW'(1);
    cell_cost = ((tl == tr) && (inner < skip_cost)) ? inner : skip_cost;
    qualifies = KCW'(cell_cost) <= KCW'(max_deletions);
    row_end   = NW'(r) == n - NW'(1);
  end

  assign cost_we = (state == S_FILL) && (ph == 2'd3);

  lnpw_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_text (
    .clk   (clk),
    .we    (text_we),
    .waddr (text_length[IW-1:0]),
    .wdata (char_byte),
    .raddr (text_raddr),
    .rdata (text_rd)
  );

  lnpw_ram #(.WIDTH(CW), .DEPTH(CDEPTH)) u_cost (
    .clk   (clk),
    .we    (cost_we),
    .waddr ({l, r}),
    .wdata (cell_cost),
    .raddr (cost_raddr),
    .rdata (cost_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      ph            <= 2'd0;
      text_length   <= '0;
      max_deletions <= '0;
      result_valid  <= 1'b0;
      best_start    <= '0;
      best_end      <= '0;
    end else begin
      if (wr_en) begin
        max_deletions <= wr_data;
      end
      if ((state == S_EMIT) && slot_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          text_length <= (char_acc && is_last) ? '0 : count_next;
          if (char_acc && is_last) begin
            n           <= count_next;
            len         <= NW'(2);
            l           <= '0;
            ph          <= 2'd0;
            bs          <= '0;
            bl          <= NW'(1);
            state       <= (count_next >= NW'(2)) ? S_FILL : S_EMIT;
          end
        end
        S_FILL: begin
          ph <= ph + 2'd1;
          case (ph)
            2'd1: begin
              a  <= cost_rd;
              tl <= text_rd;
            end
            2'd2: begin
              b  <= cost_rd;
              tr <= text_rd;
            end
            2'd3: begin
              if (qualifies && (bl != len)) begin
                bs <= l;
                bl <= len;
              end
              if (row_end) begin
                l   <= '0;
                len <= len + NW'(1);
                if (len == n) begin
                  state <= S_EMIT;
                end
              end else begin
                l <= lp1;
              end
            end
            default: begin
            end
          endcase
        end
        S_EMIT: begin
          if (slot_free) begin
            best_start   <= OUT_W'(NW'(bs) + NW'(1));
            best_end     <= OUT_W'(NW'(bs) + bl);
            state        <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule
